### rtl/tablet_serial_packet_decoder_assert.svh
// Assertion macros used by the decoder's checker file.
`ifndef TABLET_SERIAL_PACKET_DECODER_ASSERT_SVH
`define TABLET_SERIAL_PACKET_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define TSPD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define TSPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/tspd_pkg.sv
// Shared types and constants of the serial tablet packet decoder.
package tspd_pkg;

    // Frame bytes that decoding ever looks at
    localparam int HEAD_BYTES = 7;
    // Command queue between front and back
    localparam int CMD_DEPTH  = 4;
    localparam int CMD_PTR_W  = 2;
    localparam int CMD_CNT_W  = 3;

    // Characters of the ASCII responses
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_C     = 8'h43;

    typedef enum logic [1:0] {
        KIND_REPORT   = 2'd0,
        KIND_RELEASE  = 2'd1,
        KIND_RESPONSE = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        TOOL_NONE   = 2'd0,
        TOOL_STYLUS = 2'd1,
        TOOL_ERASER = 2'd2,
        TOOL_CURSOR = 2'd3
    } t_tool;

    typedef enum logic [2:0] {
        RSP_MODEL   = 3'd0,
        RSP_CONFIG  = 3'd1,
        RSP_COORDS  = 3'd2,
        RSP_OTHER   = 3'd3,
        RSP_GARBLED = 3'd4
    } t_rsp;

    // Classified frame handed from front to back
    typedef struct packed {
        logic                          is_pkt;
        t_rsp                          rsp;
        logic [HEAD_BYTES-1:0][7:0]    head;
    } t_cmd;

    // One result transaction
    typedef struct packed {
        t_kind       kind;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [8:0]  pressure;
        logic        in_proximity;
        t_tool       tool_code;
        logic        touch_button;
        logic        side_button;
        t_rsp        response_code;
        logic        last_of_run;
    } t_result;

endpackage

### rtl/tspd_front.sv
// Front end: frame assembly and classification of received bytes.
module tspd_front #(
    parameter int PACKET_BYTES = 10,
    parameter int BUFFER_BYTES = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_rx_byte,
    output logic             o_cmd_push,
    output tspd_pkg::t_cmd   o_cmd
);

    localparam int FILL_MAX = (BUFFER_BYTES > PACKET_BYTES) ? BUFFER_BYTES : PACKET_BYTES;
    localparam int FILL_W   = $clog2(FILL_MAX + 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(BUFFER_BYTES);
    localparam logic [FILL_W-1:0] FILL_PKT  = FILL_W'(PACKET_BYTES);

    logic [FILL_W-1:0]                          r_fill, n_fill;
    logic [tspd_pkg::HEAD_BYTES-1:0][7:0]       r_head;
    logic [tspd_pkg::HEAD_BYTES-1:0][7:0]       merged;
    logic [FILL_W-1:0]                          wr_idx, new_fill;
    logic                                       is_pkt, is_rsp;
    tspd_pkg::t_rsp                             rsp;

    // Write position, frame head with this byte merged in, classification
    always_comb begin
        wr_idx = (i_rx_byte[7] || (r_fill >= FILL_FULL)) ? '0 : r_fill;
        new_fill = wr_idx + FILL_W'(1);
        for (int i = 0; i < tspd_pkg::HEAD_BYTES; i++) begin
            merged[i] = (wr_idx == FILL_W'(i)) ? i_rx_byte : r_head[i];
        end
        is_pkt = (new_fill == FILL_PKT) && merged[0][7];
        is_rsp = !is_pkt && (i_rx_byte == tspd_pkg::CH_CR) && !merged[0][7];
        if ((merged[0] != tspd_pkg::CH_TILDE) || (new_fill < FILL_W'(2))) begin
            rsp = tspd_pkg::RSP_GARBLED;
        end else begin
            case (merged[1])
                tspd_pkg::CH_HASH: rsp = tspd_pkg::RSP_MODEL;
                tspd_pkg::CH_R:    rsp = tspd_pkg::RSP_CONFIG;
                tspd_pkg::CH_C:    rsp = tspd_pkg::RSP_COORDS;
                default:           rsp = tspd_pkg::RSP_OTHER;
            endcase
        end
        n_fill = (is_pkt || is_rsp) ? '0 : new_fill;
    end

    // Fill index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_accept) begin
            r_fill <= n_fill;
        end
    end

    // Head bytes of the frame; the tail is never read so is not kept
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_head <= merged;
        end
    end

    assign o_cmd_push    = i_accept && (is_pkt || is_rsp);
    assign o_cmd.is_pkt  = is_pkt;
    assign o_cmd.rsp     = rsp;
    assign o_cmd.head    = merged;

endmodule

### rtl/tspd_cmd_fifo.sv
// Short command queue between the front and back ends.
module tspd_cmd_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tspd_pkg::t_cmd   i_cmd,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output tspd_pkg::t_cmd   o_head
);

    tspd_pkg::t_cmd                   r_mem [tspd_pkg::CMD_DEPTH];
    logic [tspd_pkg::CMD_PTR_W-1:0]   r_wp, r_rp;
    logic [tspd_pkg::CMD_CNT_W-1:0]   r_cnt;
    logic                             do_push, do_pop;

    assign o_full  = (r_cnt == tspd_pkg::CMD_CNT_W'(tspd_pkg::CMD_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rp];

    // Pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop)  r_rp <= r_rp + 1'b1;
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

### rtl/tspd_back.sv
// Back end: packet decode, tool tracking and the result register.
module tspd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [1:0]         i_extra_bits,
    input  logic               i_cmd_empty,
    input  tspd_pkg::t_cmd     i_cmd,
    output logic               o_cmd_pop,
    input  logic               i_res_pop,
    output logic               o_res_valid,
    output tspd_pkg::t_result  o_res
);

    logic               r_valid, r_rel_sent;
    tspd_pkg::t_tool    r_tool;
    tspd_pkg::t_result  r_res, n_res;
    logic               load, need_rel;
    logic [7:0]         b0, b1, b2, b3, b4, b5, b6;
    logic [3:0]         button;
    tspd_pkg::t_tool    tool;
    logic [8:0]         z;

    assign b0 = i_cmd.head[0];
    assign b1 = i_cmd.head[1];
    assign b2 = i_cmd.head[2];
    assign b3 = i_cmd.head[3];
    assign b4 = i_cmd.head[4];
    assign b5 = i_cmd.head[5];
    assign b6 = i_cmd.head[6];
    assign button = b3[6:3];

    // Result slot takes a new transaction when empty or being drained
    assign load = !i_cmd_empty && (!r_valid || i_res_pop);

    // Field decode and next result
    always_comb begin
        if (b0[5]) begin
            tool = button[2] ? tspd_pkg::TOOL_ERASER : tspd_pkg::TOOL_STYLUS;
        end else begin
            tool = tspd_pkg::TOOL_CURSOR;
        end
        // pressure widened by extra bits, sign bit flipped; 3 saturates to 2
        case (i_extra_bits)
            2'd0:    z = {2'b00, b6[6:0]} ^ 9'h040;
            2'd1:    z = {1'b0, b6[6:0], b3[2]} ^ 9'h080;
            default: z = {b6[6:0], b3[2], b0[2]} ^ 9'h100;
        endcase
        need_rel = i_cmd.is_pkt && (tool != r_tool) && (r_tool != tspd_pkg::TOOL_NONE)
                   && !r_rel_sent;

        n_res = '0;
        if (!i_cmd.is_pkt) begin
            n_res.kind          = tspd_pkg::KIND_RESPONSE;
            n_res.response_code = i_cmd.rsp;
            n_res.last_of_run   = 1'b1;
        end else if (need_rel) begin
            n_res.kind          = tspd_pkg::KIND_RELEASE;
            n_res.tool_code     = r_tool;
        end else begin
            n_res.kind          = tspd_pkg::KIND_REPORT;
            n_res.pos_x         = {b0[1:0], 14'd0} | {1'b0, b1, 7'd0} | {8'd0, b2};
            n_res.pos_y         = {b3[1:0], 14'd0} | {1'b0, b4, 7'd0} | {8'd0, b5};
            n_res.pressure      = z;
            n_res.in_proximity  = b0[6];
            n_res.tool_code     = tool;
            n_res.touch_button  = button[0];
            n_res.side_button   = button[1];
            n_res.last_of_run   = 1'b1;
        end
    end

    // A release keeps the command at the queue head for its report
    assign o_cmd_pop = load && !need_rel;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_rel_sent <= 1'b0;
            r_tool     <= tspd_pkg::TOOL_NONE;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_res_pop) begin
                r_valid <= 1'b0;
            end
            if (load) begin
                if (need_rel) begin
                    r_rel_sent <= 1'b1;
                end else begin
                    r_rel_sent <= 1'b0;
                    if (i_cmd.is_pkt) r_tool <= tool;
                end
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid = r_valid;
    assign o_res       = r_res;

endmodule

### rtl/tablet_serial_packet_decoder.sv
// Top level of the serial tablet packet decoder.
//
// Input channel: one received byte per transaction on i_rx_byte, taken on a
// clock edge with push high and full low. Result channel: while empty is
// low the oldest result sits on the o_ ports and pop takes it.
// A finished binary packet gives one pen report, preceded by a release of
// the previous tool when the tool changes; a CR-terminated ASCII frame
// gives one response. o_last_of_run marks the final result of a byte.
// Throughput: one byte per cycle while full is low. The byte completing a
// frame puts its command in the queue, and the back end then loads it into
// the result register; a report after a release loads once the release is taken.
// A four-entry command queue parts the front end from the back end and a
// result register parts the back end from the receiver: while pop is held
// low the result holds, the queue fills, and full rises once it is full.
// Synchronous active-low reset empties the queue and result register,
// clears the fill index and the current tool, and sets the extra pressure
// bits register to 1. It is written through i_cfg_we / i_cfg_wdata; the
// user must write it only while the block is idle, not enforced by the block.
module tablet_serial_packet_decoder #(
    parameter int PACKET_BYTES = 10,
    parameter int BUFFER_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_kind,
    output logic [15:0] o_pos_x,
    output logic [15:0] o_pos_y,
    output logic [8:0]  o_pressure,
    output logic        o_in_proximity,
    output logic [1:0]  o_tool_code,
    output logic        o_touch_button,
    output logic        o_side_button,
    output logic [2:0]  o_response_code,
    output logic        o_last_of_run,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata
);

    logic [1:0]         r_epb;
    logic               accept, cmd_push, cmd_pop, cmd_empty, res_valid;
    tspd_pkg::t_cmd     cmd_in, cmd_head;
    tspd_pkg::t_result  res;

    assign accept = push && !full;

    // Extra pressure bits register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epb <= 2'd1;
        end else if (i_cfg_we) begin
            r_epb <= i_cfg_wdata;
        end
    end

    tspd_front #(
        .PACKET_BYTES (PACKET_BYTES),
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_rx_byte  (i_rx_byte),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in)
    );

    tspd_cmd_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .i_pop   (cmd_pop),
        .o_full  (full),
        .o_empty (cmd_empty),
        .o_head  (cmd_head)
    );

    tspd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_extra_bits (r_epb),
        .i_cmd_empty  (cmd_empty),
        .i_cmd        (cmd_head),
        .o_cmd_pop    (cmd_pop),
        .i_res_pop    (pop),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    // Result ports
    assign empty           = !res_valid;
    assign o_kind          = res.kind;
    assign o_pos_x         = res.pos_x;
    assign o_pos_y         = res.pos_y;
    assign o_pressure      = res.pressure;
    assign o_in_proximity  = res.in_proximity;
    assign o_tool_code     = res.tool_code;
    assign o_touch_button  = res.touch_button;
    assign o_side_button   = res.side_button;
    assign o_response_code = res.response_code;
    assign o_last_of_run   = res.last_of_run;

endmodule

### rtl/tspd_checker.sv
// Port-level checker of the decoder, bound to the top level.
`include "tablet_serial_packet_decoder_assert.svh"

module tspd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  o_kind,
    input logic [15:0] o_pos_x,
    input logic [1:0]  o_tool_code,
    input logic [2:0]  o_response_code,
    input logic        o_last_of_run
);

    logic       rel_shown, rpt_shown, rel_clean, stalled;
    logic [4:0] shown_code;

    assign rel_shown  = !empty && (o_kind == tspd_pkg::KIND_RELEASE);
    assign rpt_shown  = !empty && (o_kind == tspd_pkg::KIND_REPORT);
    assign rel_clean  = (o_tool_code != tspd_pkg::TOOL_NONE) && (o_pos_x == 16'd0);
    assign stalled    = !empty && !pop;
    assign shown_code = {o_kind, o_response_code};

    // Only a release is not the last result of its byte
    `TSPD_ASSERT_NOW(a_last_mark, !empty, o_last_of_run == !rel_shown, "last_of_run mismatch")

    // A release names a real tool and carries a zero x position
    `TSPD_ASSERT_NOW(a_rel_tool, rel_shown, rel_clean, "bad release")

    // A taken release is followed at once by its pen report
    `TSPD_ASSERT_NEXT(a_rel_then_rpt, rel_shown && pop, rpt_shown, "no report after release")

    // A stalled result transaction holds its kind and response code
    `TSPD_ASSERT_NEXT(a_stall_hold, stalled, !empty && $stable(shown_code), "stall not held")

endmodule

bind tablet_serial_packet_decoder tspd_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .empty           (empty),
    .pop             (pop),
    .o_kind          (o_kind),
    .o_pos_x         (o_pos_x),
    .o_tool_code     (o_tool_code),
    .o_response_code (o_response_code),
    .o_last_of_run   (o_last_of_run)
);
